FILE: src/bscpe_pkg.sv
// Shared types and constants for the bit-stuffed CRC frame pulse encoder.
// No dependencies.
package bscpe_pkg;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_PAIR  = 2'd2;
  localparam logic [1:0] OP_END   = 2'd3;

  localparam logic [1:0] CFG_MARK     = 2'd0;
  localparam logic [1:0] CFG_ZERO     = 2'd1;
  localparam logic [1:0] CFG_EXTRA    = 2'd2;
  localparam logic [1:0] CFG_END_MARK = 2'd3;

  localparam logic [7:0]  MARK_RST     = 8'd18;
  localparam logic [7:0]  ZERO_RST     = 8'd14;
  localparam logic [7:0]  EXTRA_RST    = 8'd16;
  localparam logic [15:0] END_MARK_RST = 16'd18010;

  localparam logic [15:0] CRC_POLY    = 16'h8408;
  localparam logic [13:0] CHAN_OFFSET = 14'd2250;
  localparam logic [2:0]  STUFF_RUN   = 3'd5;
  localparam logic [7:0]  FLAG_BYTE   = 8'h7E;

  typedef struct packed {
    logic [1:0]         op;
    logic [7:0]         data_byte;
    logic signed [11:0] first_channel;
    logic signed [11:0] second_channel;
  } in_item_t;

  typedef struct packed {
    logic [15:0] edge_time;
    logic        last_of_run;
  } out_item_t;

  // One line bit (or the closing end mark) handed to the edge timer.
  typedef struct packed {
    logic clr;   // restart line time at zero before this bit
    logic endm;  // emit the end mark edge instead of a bit
    logic one;
    logic last;  // final edge of this bit closes the transfer run
  } line_req_t;

endpackage

FILE: src/bscpe_chan_map.sv
// Channel pair mapping c = v*3/4 + offset, registered on load.
// Depends on bscpe_pkg.
module bscpe_chan_map
  import bscpe_pkg::*;
(
  input  logic               clk_i,
  input  logic               load_i,
  input  logic signed [11:0] first_i,
  input  logic signed [11:0] second_i,
  output logic [11:0]        chan0_o,
  output logic [11:0]        chan1_o
);

  function automatic logic [11:0] map_chan(logic signed [11:0] v);
    logic signed [13:0] triple;
    logic signed [13:0] biased;
    logic signed [13:0] scaled;
    logic [13:0]        sum;
    triple = {{2{v[11]}}, v} + {v[11], v, 1'b0};
    // bias negatives so the shift truncates toward zero
    biased = triple + (triple[13] ? 14'sd3 : 14'sd0);
    scaled = biased >>> 2;
    sum    = scaled + CHAN_OFFSET;
    return sum[11:0];
  endfunction

  logic [11:0] chan0_q, chan1_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      chan0_q <= map_chan(first_i);
      chan1_q <= map_chan(second_i);
    end
  end

  assign chan0_o = chan0_q;
  assign chan1_o = chan1_q;

endmodule

FILE: src/bscpe_crc_ser.sv
// Reflected CRC-16 (poly 0x8408), one bit per cycle, LSB first.
// Depends on bscpe_pkg.
module bscpe_crc_ser
  import bscpe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        clear_i,
  input  logic        load_i,
  input  logic [7:0]  byte_i,
  output logic [15:0] crc_o
);

  localparam logic [3:0] BYTE_BITS = 4'd8;

  logic [15:0] crc_q;
  logic [7:0]  sh_q;
  logic [3:0]  cnt_q;
  logic        fb;

  assign fb = crc_q[0] ^ sh_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= '0;
      sh_q  <= '0;
      cnt_q <= '0;
    end else if (clear_i) begin
      crc_q <= '0;
      cnt_q <= '0;
    end else if (load_i) begin
      sh_q  <= byte_i;
      cnt_q <= BYTE_BITS;
    end else if (cnt_q != 4'd0) begin
      crc_q <= (crc_q >> 1) ^ (fb ? CRC_POLY : 16'd0);
      sh_q  <= sh_q >> 1;
      cnt_q <= cnt_q - 4'd1;
    end
  end

  assign crc_o = crc_q;

endmodule

FILE: src/bscpe_bit_seq.sv
// Item sequencer: byte queue, MSB-first bit shifter, zero stuffing, flags.
// Depends on bscpe_pkg; feeds bscpe_crc_ser and bscpe_edge_gen.
module bscpe_bit_seq
  import bscpe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  input  logic [11:0] chan0_i,
  input  logic [11:0] chan1_i,
  input  logic [15:0] crc_i,
  output logic        crc_clear_o,
  output logic        crc_load_o,
  output logic [7:0]  crc_byte_o,
  output logic        req_valid_o,
  output line_req_t   req_o,
  input  logic        req_ready_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_SETUP, S_LOAD, S_BITS, S_FLAG, S_ENDM
  } state_e;

  state_e      st_q;
  logic [1:0]  op_q;
  logic [7:0]  data_q;
  logic [23:0] bytes_q;
  logic [1:0]  nrem_q;
  logic [7:0]  sh_q;
  logic [2:0]  bit_cnt_q;
  logic        stuff_q;
  logic [2:0]  ones_q;
  logic [2:0]  fidx_q;
  logic        flag_q;
  logic        end_q;
  logic        clr_q;

  logic cur_one, will_stuff, byte_end, more_after;
  logic take;

  assign in_stall_o  = (st_q != S_IDLE);
  assign take        = req_valid_o && req_ready_i;
  assign cur_one     = !stuff_q && sh_q[7];
  assign will_stuff  = cur_one && (ones_q == STUFF_RUN - 3'd1);
  assign byte_end    = (bit_cnt_q == 3'd0) && (stuff_q || !will_stuff);
  assign more_after  = (nrem_q != 2'd0) || flag_q || end_q;

  assign crc_clear_o = (st_q == S_SETUP) && (op_q == OP_START);
  assign crc_load_o  = (st_q == S_LOAD);
  assign crc_byte_o  = bytes_q[7:0];

  always_comb begin
    req_valid_o = 1'b0;
    req_o       = '0;
    unique case (st_q)
      S_BITS: begin
        req_valid_o = 1'b1;
        req_o.one   = cur_one;
        req_o.last  = byte_end && !more_after;
      end
      S_FLAG: begin
        req_valid_o = 1'b1;
        req_o.clr   = clr_q;
        req_o.one   = FLAG_BYTE[3'd7 - fidx_q];
        req_o.last  = (fidx_q == 3'd7) && !end_q;
      end
      S_ENDM: begin
        req_valid_o = 1'b1;
        req_o.endm  = 1'b1;
        req_o.last  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      op_q      <= OP_START;
      data_q    <= '0;
      bytes_q   <= '0;
      nrem_q    <= '0;
      sh_q      <= '0;
      bit_cnt_q <= '0;
      stuff_q   <= 1'b0;
      ones_q    <= '0;
      fidx_q    <= '0;
      flag_q    <= 1'b0;
      end_q     <= 1'b0;
      clr_q     <= 1'b0;
    end else begin
      unique case (st_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q   <= in_data_i.op;
            data_q <= in_data_i.data_byte;
            st_q   <= S_SETUP;
          end
        end
        S_SETUP: begin
          unique case (op_q)
            OP_START: begin
              ones_q <= '0;
              clr_q  <= 1'b1;
              flag_q <= 1'b1;
              end_q  <= 1'b0;
              fidx_q <= '0;
              st_q   <= S_FLAG;
            end
            OP_BYTE: begin
              bytes_q <= {16'd0, data_q};
              nrem_q  <= 2'd1;
              flag_q  <= 1'b0;
              end_q   <= 1'b0;
              st_q    <= S_LOAD;
            end
            OP_PAIR: begin
              bytes_q <= {chan1_i[11:4], chan1_i[3:0], chan0_i[11:8], chan0_i[7:0]};
              nrem_q  <= 2'd3;
              flag_q  <= 1'b0;
              end_q   <= 1'b0;
              st_q    <= S_LOAD;
            end
            default: begin
              // end of frame: CRC low byte, high byte, flag, end mark
              bytes_q <= {8'd0, crc_i};
              nrem_q  <= 2'd2;
              flag_q  <= 1'b1;
              end_q   <= 1'b1;
              st_q    <= S_LOAD;
            end
          endcase
        end
        S_LOAD: begin
          sh_q      <= bytes_q[7:0];
          bytes_q   <= bytes_q >> 8;
          nrem_q    <= nrem_q - 2'd1;
          bit_cnt_q <= 3'd7;
          stuff_q   <= 1'b0;
          st_q      <= S_BITS;
        end
        S_BITS: begin
          if (take) begin
            if (will_stuff) begin
              ones_q  <= '0;
              stuff_q <= 1'b1;
            end else begin
              stuff_q <= 1'b0;
              ones_q  <= cur_one ? ones_q + 3'd1 : 3'd0;
              if (bit_cnt_q == 3'd0) begin
                if (nrem_q != 2'd0) begin
                  st_q <= S_LOAD;
                end else if (flag_q) begin
                  fidx_q <= '0;
                  st_q   <= S_FLAG;
                end else begin
                  st_q <= S_IDLE;
                end
              end else begin
                bit_cnt_q <= bit_cnt_q - 3'd1;
                sh_q      <= sh_q << 1;
              end
            end
          end
        end
        S_FLAG: begin
          if (take) begin
            clr_q <= 1'b0;
            if (fidx_q == 3'd7) begin
              st_q <= end_q ? S_ENDM : S_IDLE;
            end else begin
              fidx_q <= fidx_q + 3'd1;
            end
          end
        end
        S_ENDM: begin
          if (take) st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: src/bscpe_edge_gen.sv
// Edge timer: line bit to mark and space edge times; holds the output register.
// Depends on bscpe_pkg.
module bscpe_edge_gen
  import bscpe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  mark_i,
  input  logic [7:0]  zero_i,
  input  logic [7:0]  extra_i,
  input  logic [15:0] end_mark_i,
  input  logic        req_valid_i,
  input  line_req_t   req_i,
  output logic        req_ready_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o
);

  typedef enum logic [1:0] { PH_IDLE, PH_FIRST, PH_SECOND } phase_e;

  phase_e      ph_q;
  line_req_t   req_q;
  logic [8:0]  space_q;
  logic [15:0] time_q;
  logic        out_valid_q;
  out_item_t   out_q;

  logic        load_ok;
  logic [8:0]  space_d;
  logic [15:0] time_first_d, time_second_d;

  assign load_ok       = !out_valid_q || !out_stall_i;
  assign req_ready_o   = (ph_q == PH_IDLE) || ((ph_q == PH_SECOND) && load_ok);
  assign space_d       = {1'b0, zero_i} + (req_i.one ? {1'b0, extra_i} : 9'd0);
  assign time_first_d  = (req_q.clr ? 16'd0 : time_q) + {8'd0, mark_i};
  assign time_second_d = time_q + {7'd0, space_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q        <= PH_IDLE;
      req_q       <= '0;
      space_q     <= '0;
      time_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // both edge phases load the output register whenever it is free
      if (load_ok) out_valid_q <= (ph_q == PH_FIRST) || (ph_q == PH_SECOND);
      unique case (ph_q)
        PH_IDLE: begin
          if (req_valid_i) begin
            req_q   <= req_i;
            space_q <= space_d;
            ph_q    <= PH_FIRST;
          end
        end
        PH_FIRST: begin
          if (load_ok) begin
            if (req_q.endm) begin
              // end mark leaves line time alone
              out_q <= '{edge_time: end_mark_i, last_of_run: 1'b1};
              ph_q  <= PH_IDLE;
            end else begin
              out_q  <= '{edge_time: time_first_d, last_of_run: 1'b0};
              time_q <= time_first_d;
              ph_q   <= PH_SECOND;
            end
          end
        end
        PH_SECOND: begin
          if (load_ok) begin
            out_q  <= '{edge_time: time_second_d, last_of_run: req_q.last};
            time_q <= time_second_d;
            if (req_valid_i) begin
              req_q   <= req_i;
              space_q <= space_d;
              ph_q    <= PH_FIRST;
            end else begin
              ph_q <= PH_IDLE;
            end
          end
        end
        default: ph_q <= PH_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: src/bit_stuffed_crc_frame_pulse_encoder.sv
// Frame pulse encoder: start / byte / channel pair / end items in, edge times out.
// Start items go from setup straight to the flag; other items load a byte first.
// One edge per cycle unless stalled, two per line bit; byte loads overlap the prior bit.
// A new input transfer is taken once the sequencer has handed its last line bit or end
// mark to the edge timer; the last edges of the transfer may then still be going out.
// Reset: config to defaults, line time, CRC and ones run to zero; no clear pass.
module bit_stuffed_crc_frame_pulse_encoder
  import bscpe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  logic [7:0]  mark_q, zero_q, extra_q;
  logic [15:0] end_mark_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q     <= MARK_RST;
      zero_q     <= ZERO_RST;
      extra_q    <= EXTRA_RST;
      end_mark_q <= END_MARK_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MARK:  mark_q  <= cfg_data_i[7:0];
        CFG_ZERO:  zero_q  <= cfg_data_i[7:0];
        CFG_EXTRA: extra_q <= cfg_data_i[7:0];
        default:   end_mark_q <= cfg_data_i;
      endcase
    end
  end

  logic [11:0] chan0, chan1;
  logic [15:0] crc;
  logic        crc_clear, crc_load;
  logic [7:0]  crc_byte;
  logic        req_valid, req_ready;
  line_req_t   req;

  bscpe_chan_map u_chan_map (
    .clk_i    (clk_i),
    .load_i   (in_valid_i && !in_stall_o),
    .first_i  (in_data_i.first_channel),
    .second_i (in_data_i.second_channel),
    .chan0_o  (chan0),
    .chan1_o  (chan1)
  );

  bscpe_crc_ser u_crc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (crc_clear),
    .load_i  (crc_load),
    .byte_i  (crc_byte),
    .crc_o   (crc)
  );

  bscpe_bit_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .chan0_i     (chan0),
    .chan1_i     (chan1),
    .crc_i       (crc),
    .crc_clear_o (crc_clear),
    .crc_load_o  (crc_load),
    .crc_byte_o  (crc_byte),
    .req_valid_o (req_valid),
    .req_o       (req),
    .req_ready_i (req_ready)
  );

  bscpe_edge_gen u_edge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mark_i      (mark_q),
    .zero_i      (zero_q),
    .extra_i     (extra_q),
    .end_mark_i  (end_mark_q),
    .req_valid_i (req_valid),
    .req_i       (req),
    .req_ready_o (req_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
